[src/bsrp_pkg.sv]
package bsrp_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int TAG_W    = 16;
    localparam int PROD_W   = 2 * COORD_W;
    localparam int TERM_W   = PROD_W - FRAC_W;
    // three product terms plus one element
    localparam int ACC_W    = TERM_W + 2;
    localparam int NUM_W    = ACC_W + 2;
    localparam int DIV_W    = NUM_W;
    localparam int QUO_W    = FRAC_W;
    localparam int OUT_W    = FRAC_W + 1;
    // signed holder for -1 .. one plus one LSB
    localparam int RAT_W    = OUT_W + 1;

    localparam logic signed [RAT_W-1:0] RAT_BELOW = -18'sd1;
    localparam logic signed [RAT_W-1:0] RAT_ONE   = 18'sd65536;
    localparam logic signed [RAT_W-1:0] RAT_ABOVE = 18'sd65537;
    localparam logic signed [RAT_W-1:0] RAT_ZERO  = 18'sd0;

    localparam logic signed [COORD_W-1:0] FIX_ONE = 32'sd65536;
    localparam logic [COORD_W-1:0] FAR_RESET = 32'd65536000;

    localparam logic [1:0] OP_LOAD_PROJ = 2'd0;
    localparam logic [1:0] OP_LOAD_VIEW = 2'd1;
    localparam logic [1:0] OP_PROJECT   = 2'd2;

    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR  = 1'b1;

    localparam logic [1:0] SEL_U = 2'd0;
    localparam logic [1:0] SEL_V = 2'd1;
    localparam logic [1:0] SEL_D = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_CHECK,
        ST_RSET,
        ST_RWAIT,
        ST_MERGE,
        ST_NEXT,
        ST_DONE
    } state_t;

endpackage

[src/bsrp_div.sv]
module bsrp_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [bsrp_pkg::DIV_W-1:0]       num,
    input  logic [bsrp_pkg::DIV_W-1:0]       den,
    output logic                             done,
    output logic [bsrp_pkg::QUO_W-1:0]       quo
);

    logic [bsrp_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [bsrp_pkg::DIV_W-1:0] den_reg, den_next;
    logic [bsrp_pkg::QUO_W-1:0] quo_reg, quo_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [bsrp_pkg::DIV_W:0]   rem2;

    always_comb begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem2      = {rem_reg, 1'b0};
        if (start) begin
            rem_next  = num;
            den_next  = den;
            quo_next  = '0;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // one quotient bit a cycle
            if (rem2 >= {1'b0, den_reg}) begin
                rem_next = bsrp_pkg::DIV_W'(rem2 - {1'b0, den_reg});
                quo_next = {quo_reg[bsrp_pkg::QUO_W-2:0], 1'b1};
            end else begin
                rem_next = bsrp_pkg::DIV_W'(rem2);
                quo_next = {quo_reg[bsrp_pkg::QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[src/box_screen_rect_projector.sv]
// Projects an axis-aligned box to a screen-space rectangle and linear depth
// range. Opcode 0/1 beats write one element of the projection/view matrix
// (row vectors, signed Q16.16). An opcode 2 beat runs the eight box corners
// one after the other through a single shared 32x32 multiplier (16 products
// per corner for clip x, y, w and view z) and a shared one-bit-per-cycle
// divider (used for each of u, v and depth whose ratio is at least 0 and
// below 1); s_ready is low while a project beat runs, including any wait for
// m_ready.
// Corners with clip w <= 0 are skipped; the rectangle comes out clamped to
// Q1.16 0..1 with rect_valid low (and all rectangle and depth fields 0) when
// no corner counts or the box lies wholly off-screen. near_plane (index 0)
// and far_plane (index 1) are written through the cfg port; the user must do
// so only while the block is idle, as the block itself does not enforce it.
module box_screen_rect_projector (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [3:0]  s_element_slot,
    input  logic signed [31:0] s_element_value,
    input  logic signed [31:0] s_box_min_x,
    input  logic signed [31:0] s_box_min_y,
    input  logic signed [31:0] s_box_min_z,
    input  logic signed [31:0] s_box_max_x,
    input  logic signed [31:0] s_box_max_y,
    input  logic signed [31:0] s_box_max_z,
    input  logic [15:0] s_object_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_rect_valid,
    output logic [16:0] m_u_low,
    output logic [16:0] m_v_low,
    output logic [16:0] m_u_high,
    output logic [16:0] m_v_high,
    output logic [16:0] m_depth_low,
    output logic [16:0] m_depth_high,
    output logic [15:0] m_result_tag
);

    localparam int CW = bsrp_pkg::COORD_W;
    localparam int AW = bsrp_pkg::ACC_W;
    localparam int NW = bsrp_pkg::NUM_W;
    localparam int RW = bsrp_pkg::RAT_W;
    localparam int OW = bsrp_pkg::OUT_W;

    bsrp_pkg::state_t state_reg, state_next;

    // matrices and planes
    logic [CW-1:0] proj_reg [16];
    logic [CW-1:0] view_reg [16];
    logic [CW-1:0] near_reg, far_reg;

    // item held for the whole project run
    logic signed [CW-1:0] bmin_reg [3];
    logic signed [CW-1:0] bmax_reg [3];
    logic [15:0]          tag_reg;

    logic [2:0] corner_reg, corner_next;
    logic [4:0] step_reg, step_next;
    logic [1:0] sel_reg, sel_next;

    logic signed [bsrp_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [AW-1:0] acc_reg [4];
    logic signed [AW-1:0] acc_wdata;
    logic                 acc_we;

    logic signed [RW-1:0] cur_reg [3];
    logic signed [RW-1:0] cur_wdata;
    logic                 cur_we;

    logic                 used_reg, used_next;
    logic signed [RW-1:0] ulo_reg, uhi_reg, vlo_reg, vhi_reg, dlo_reg, dhi_reg;

    // output register
    logic          m_valid_reg;
    logic          o_ok_reg;
    logic [OW-1:0] o_ulo_reg, o_vlo_reg, o_uhi_reg, o_vhi_reg, o_dlo_reg, o_dhi_reg;
    logic [15:0]   o_tag_reg;
    logic          out_load;

    logic                 div_start;
    logic                 div_done;
    logic signed [NW-1:0] num, den;
    logic [bsrp_pkg::QUO_W-1:0] quo;

    logic s_fire;
    assign s_ready = (state_reg == bsrp_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    // --------------------------------------------------------------
    // multiply-accumulate operand select
    // --------------------------------------------------------------
    logic [1:0] o_idx, i_idx, o_prev, i_prev;
    logic [1:0] col;
    logic [3:0] elem_addr;
    logic signed [CW-1:0] elem, coord;
    logic [4:0] step_prev;

    assign o_idx     = step_reg[3:2];
    assign i_idx     = step_reg[1:0];
    assign step_prev = step_reg - 5'd1;
    assign o_prev    = step_prev[3:2];
    assign i_prev    = step_prev[1:0];

    always_comb begin
        unique case (o_idx)
            2'd0:    col = 2'd0;
            2'd1:    col = 2'd1;
            2'd2:    col = 2'd3;
            default: col = 2'd2;
        endcase
        elem_addr = {i_idx, col};
        elem = (o_idx == 2'd3) ? view_reg[elem_addr] : proj_reg[elem_addr];
        unique case (i_idx)
            2'd0:    coord = corner_reg[0] ? bmax_reg[0] : bmin_reg[0];
            2'd1:    coord = corner_reg[1] ? bmax_reg[1] : bmin_reg[1];
            2'd2:    coord = corner_reg[2] ? bmax_reg[2] : bmin_reg[2];
            // the row-3 element enters scaled by 1.0, exact after the floor
            default: coord = bsrp_pkg::FIX_ONE;
        endcase
    end

    // --------------------------------------------------------------
    // ratio setup
    // --------------------------------------------------------------
    logic signed [NW-1:0] zn, zf;
    logic depth_off;

    assign zn = NW'(signed'(near_reg));
    assign zf = NW'(signed'(far_reg));
    assign depth_off = (zf <= zn);

    always_comb begin
        unique case (sel_reg)
            bsrp_pkg::SEL_U: begin
                num = NW'(acc_reg[0]) + NW'(acc_reg[2]);
                den = NW'(acc_reg[2]) <<< 1;
            end
            bsrp_pkg::SEL_V: begin
                num = NW'(acc_reg[1]) + NW'(acc_reg[2]);
                den = NW'(acc_reg[2]) <<< 1;
            end
            default: begin
                num = NW'(acc_reg[3]) - zn;
                den = zf - zn;
            end
        endcase
    end

    bsrp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (bsrp_pkg::DIV_W'(num)),
        .den     (bsrp_pkg::DIV_W'(den)),
        .done    (div_done),
        .quo     (quo)
    );

    // --------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------
    logic signed [bsrp_pkg::TERM_W-1:0] term;
    assign term = prod_reg[bsrp_pkg::PROD_W-1:bsrp_pkg::FRAC_W];

    always_comb begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        step_next     = step_reg;
        sel_next      = sel_reg;
        prod_next     = prod_reg;
        used_next     = used_reg;
        acc_we        = 1'b0;
        acc_wdata     = (i_prev == 2'd0) ? AW'(term) : acc_reg[o_prev] + AW'(term);
        cur_we        = 1'b0;
        cur_wdata     = bsrp_pkg::RAT_ZERO;
        div_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            bsrp_pkg::ST_IDLE: begin
                if (s_fire && s_opcode == bsrp_pkg::OP_PROJECT) begin
                    corner_next = '0;
                    step_next   = '0;
                    used_next   = 1'b0;
                    state_next  = bsrp_pkg::ST_MAC;
                end
            end
            bsrp_pkg::ST_MAC: begin
                // product of this step, accumulate the previous one
                prod_next = coord * signed'(elem);
                if (step_reg != 5'd0) begin
                    acc_we = 1'b1;
                end
                if (step_reg == 5'd16) begin
                    state_next = bsrp_pkg::ST_CHECK;
                end else begin
                    step_next = step_reg + 5'd1;
                end
            end
            bsrp_pkg::ST_CHECK: begin
                sel_next = bsrp_pkg::SEL_U;
                // drop corners at or behind the eye plane
                state_next = (acc_reg[2] <= 0) ? bsrp_pkg::ST_NEXT : bsrp_pkg::ST_RSET;
            end
            bsrp_pkg::ST_RSET: begin
                priority if (sel_reg == bsrp_pkg::SEL_D && depth_off) begin
                    cur_we    = 1'b1;
                    cur_wdata = bsrp_pkg::RAT_ZERO;
                end else if (num < 0) begin
                    cur_we    = 1'b1;
                    cur_wdata = (sel_reg == bsrp_pkg::SEL_D) ? bsrp_pkg::RAT_ZERO
                                                             : bsrp_pkg::RAT_BELOW;
                end else if (num > den) begin
                    cur_we    = 1'b1;
                    cur_wdata = (sel_reg == bsrp_pkg::SEL_D) ? bsrp_pkg::RAT_ONE
                                                             : bsrp_pkg::RAT_ABOVE;
                end else if (num == den) begin
                    cur_we    = 1'b1;
                    cur_wdata = bsrp_pkg::RAT_ONE;
                end else begin
                    div_start  = 1'b1;
                    state_next = bsrp_pkg::ST_RWAIT;
                end
                if (cur_we) begin
                    if (sel_reg == bsrp_pkg::SEL_D) begin
                        state_next = bsrp_pkg::ST_MERGE;
                    end else begin
                        sel_next = sel_reg + 2'd1;
                    end
                end
            end
            bsrp_pkg::ST_RWAIT: begin
                if (div_done) begin
                    cur_we    = 1'b1;
                    cur_wdata = RW'(quo);
                    if (sel_reg == bsrp_pkg::SEL_D) begin
                        state_next = bsrp_pkg::ST_MERGE;
                    end else begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = bsrp_pkg::ST_RSET;
                    end
                end
            end
            bsrp_pkg::ST_MERGE: begin
                used_next  = 1'b1;
                state_next = bsrp_pkg::ST_NEXT;
            end
            bsrp_pkg::ST_NEXT: begin
                step_next = '0;
                if (corner_reg == 3'd7) begin
                    state_next = bsrp_pkg::ST_DONE;
                end else begin
                    corner_next = corner_reg + 3'd1;
                    state_next  = bsrp_pkg::ST_MAC;
                end
            end
            bsrp_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = bsrp_pkg::ST_IDLE;
                end
            end
            default: state_next = bsrp_pkg::ST_IDLE;
        endcase
    end

    // --------------------------------------------------------------
    // result decision
    // --------------------------------------------------------------
    logic ok;
    assign ok = used_reg && !(uhi_reg < 0 || vhi_reg < 0 ||
                              ulo_reg > bsrp_pkg::RAT_ONE || vlo_reg > bsrp_pkg::RAT_ONE);

    function automatic logic [bsrp_pkg::OUT_W-1:0] clamp01(
        input logic signed [bsrp_pkg::RAT_W-1:0] v
    );
        if (v < 0)                 return '0;
        if (v > bsrp_pkg::RAT_ONE) return bsrp_pkg::OUT_W'(bsrp_pkg::RAT_ONE);
        return v[bsrp_pkg::OUT_W-1:0];
    endfunction

    // --------------------------------------------------------------
    // registers
    // --------------------------------------------------------------
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (acc_we) begin
            acc_reg[o_prev] <= acc_wdata;
        end
        if (cur_we) begin
            cur_reg[sel_reg] <= cur_wdata;
        end
        if (s_fire && s_opcode == bsrp_pkg::OP_PROJECT) begin
            bmin_reg[0] <= s_box_min_x;
            bmin_reg[1] <= s_box_min_y;
            bmin_reg[2] <= s_box_min_z;
            bmax_reg[0] <= s_box_max_x;
            bmax_reg[1] <= s_box_max_y;
            bmax_reg[2] <= s_box_max_z;
            tag_reg     <= s_object_tag;
        end
        if (state_reg == bsrp_pkg::ST_MERGE) begin
            if (!used_reg || cur_reg[0] < ulo_reg) ulo_reg <= cur_reg[0];
            if (!used_reg || cur_reg[0] > uhi_reg) uhi_reg <= cur_reg[0];
            if (!used_reg || cur_reg[1] < vlo_reg) vlo_reg <= cur_reg[1];
            if (!used_reg || cur_reg[1] > vhi_reg) vhi_reg <= cur_reg[1];
            if (!used_reg || cur_reg[2] < dlo_reg) dlo_reg <= cur_reg[2];
            if (!used_reg || cur_reg[2] > dhi_reg) dhi_reg <= cur_reg[2];
        end
        if (out_load) begin
            o_ok_reg  <= ok;
            o_ulo_reg <= ok ? clamp01(ulo_reg) : '0;
            o_vlo_reg <= ok ? clamp01(vlo_reg) : '0;
            o_uhi_reg <= ok ? clamp01(uhi_reg) : '0;
            o_vhi_reg <= ok ? clamp01(vhi_reg) : '0;
            o_dlo_reg <= ok ? clamp01(dlo_reg) : '0;
            o_dhi_reg <= ok ? clamp01(dhi_reg) : '0;
            o_tag_reg <= tag_reg;
        end

        if (!aresetn) begin
            state_reg   <= bsrp_pkg::ST_IDLE;
            corner_reg  <= '0;
            step_reg    <= '0;
            sel_reg     <= '0;
            used_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            near_reg    <= '0;
            far_reg     <= bsrp_pkg::FAR_RESET;
            for (int k = 0; k < 16; k++) begin
                proj_reg[k] <= '0;
                view_reg[k] <= '0;
            end
        end else begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            step_reg   <= step_next;
            sel_reg    <= sel_next;
            used_reg   <= used_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_we) begin
                if (cfg_index == bsrp_pkg::REG_NEAR) near_reg <= cfg_wdata;
                else                                 far_reg  <= cfg_wdata;
            end
            if (s_fire && s_opcode == bsrp_pkg::OP_LOAD_PROJ) begin
                proj_reg[s_element_slot] <= s_element_value;
            end
            if (s_fire && s_opcode == bsrp_pkg::OP_LOAD_VIEW) begin
                view_reg[s_element_slot] <= s_element_value;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_rect_valid = o_ok_reg;
    assign m_u_low      = o_ulo_reg;
    assign m_v_low      = o_vlo_reg;
    assign m_u_high     = o_uhi_reg;
    assign m_v_high     = o_vhi_reg;
    assign m_depth_low  = o_dlo_reg;
    assign m_depth_high = o_dhi_reg;
    assign m_result_tag = o_tag_reg;

    // --------------------------------------------------------------
    // assertions
    // --------------------------------------------------------------
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_rect_valid |-> m_u_low == '0 && m_u_high == '0 &&
                                     m_depth_low == '0 && m_depth_high == '0)
        else $error("rejected beat carries nonzero rectangle");

    a_rect_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rect_valid |-> m_u_low <= m_u_high && m_v_low <= m_v_high &&
                                    m_depth_low <= m_depth_high)
        else $error("rectangle edges out of order");

    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |=> state_reg == bsrp_pkg::ST_RWAIT)
        else $error("divider started outside ratio wait");

endmodule

[tb/sv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Q16.16 unit, also the scale of the camera distance range the random boxes use.
    localparam int ONE_Q16 = 65536;
    // Hold-off before cfg writes and before the final check.
    localparam int DRAIN_CYCLES = 800;

    typedef logic signed [31:0] box_t [6];

    typedef struct {
        logic        rect_valid;
        logic [16:0] u_low;
        logic [16:0] v_low;
        logic [16:0] u_high;
        logic [16:0] v_high;
        logic [16:0] depth_low;
        logic [16:0] depth_high;
        logic [15:0] tag;
    } rect_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [3:0]  s_element_slot;
    logic signed [31:0] s_element_value;
    logic signed [31:0] s_box_min_x, s_box_min_y, s_box_min_z;
    logic signed [31:0] s_box_max_x, s_box_max_y, s_box_max_z;
    logic [15:0] s_object_tag;
    logic        m_valid;
    logic        m_ready;
    logic        m_rect_valid;
    logic [16:0] m_u_low, m_v_low, m_u_high, m_v_high, m_depth_low, m_depth_high;
    logic [15:0] m_result_tag;

    box_screen_rect_projector u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_element_slot  (s_element_slot),
        .s_element_value (s_element_value),
        .s_box_min_x     (s_box_min_x),
        .s_box_min_y     (s_box_min_y),
        .s_box_min_z     (s_box_min_z),
        .s_box_max_x     (s_box_max_x),
        .s_box_max_y     (s_box_max_y),
        .s_box_max_z     (s_box_max_z),
        .s_object_tag    (s_object_tag),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rect_valid    (m_rect_valid),
        .m_u_low         (m_u_low),
        .m_v_low         (m_v_low),
        .m_u_high        (m_u_high),
        .m_v_high        (m_v_high),
        .m_depth_low     (m_depth_low),
        .m_depth_high    (m_depth_high),
        .m_result_tag    (m_result_tag)
    );

    // Shadow copy of the block's matrices and plane registers.
    logic signed [31:0] proj_mat [16];
    logic signed [31:0] view_mat [16];
    logic signed [31:0] near_q;
    logic signed [31:0] far_q;

    rect_t rect_queue [$];
    int    error_count;
    int    burst_left;
    bit    rx_random;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Ratio n/d in Q16.16 for d > 0: -1 below zero, one LSB over 1.0 above one.
    function automatic int ratio_q16(longint n, longint d);
        longint r;
        int q;
        if (n < 0) return -1;
        if (n > d) return ONE_Q16 + 1;
        if (n == d) return ONE_Q16;
        r = n;
        q = 0;
        for (int b = 0; b < 16; b++) begin
            r = r * 2;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic int clamp_unit(int v);
        if (v < 0) return 0;
        if (v > ONE_Q16) return ONE_Q16;
        return v;
    endfunction

    // Row vector (x,y,z,1) times a 4x4 Q16.16 matrix; products floored, no saturation.
    function automatic longint transform_col(longint p[3], logic signed [31:0] m[16], int j);
        longint acc;
        acc = longint'(m[12 + j]);
        for (int i = 0; i < 3; i++)
            acc += (p[i] * longint'(m[i * 4 + j])) >>> 16;
        return acc;
    endfunction

    function automatic int depth_of(longint z);
        longint zn;
        longint zf;
        zn = longint'(near_q);
        zf = longint'(far_q);
        if (zf <= zn) return 0;
        return clamp_unit(ratio_q16(z - zn, zf - zn));
    endfunction

    function automatic rect_t project_box(box_t b, logic [15:0] tag);
        rect_t  r;
        longint p[3];
        longint cx, cy, cw, vz;
        int     u, v, d;
        int     ulo, uhi, vlo, vhi, dlo, dhi;
        int     used;
        bit     ok;
        used = 0;
        ulo = 0; uhi = 0; vlo = 0; vhi = 0; dlo = 0; dhi = 0;
        for (int c = 0; c < 8; c++) begin
            p[0] = longint'(c[0] ? b[3] : b[0]);
            p[1] = longint'(c[1] ? b[4] : b[1]);
            p[2] = longint'(c[2] ? b[5] : b[2]);
            cw = transform_col(p, proj_mat, 3);
            // skip corners at or behind the camera plane
            if (cw <= 0) continue;
            cx = transform_col(p, proj_mat, 0);
            cy = transform_col(p, proj_mat, 1);
            u = ratio_q16(cx + cw, 2 * cw);
            v = ratio_q16(cy + cw, 2 * cw);
            vz = transform_col(p, view_mat, 2);
            d = depth_of(vz);
            if (used == 0) begin
                ulo = u; uhi = u; vlo = v; vhi = v; dlo = d; dhi = d;
            end else begin
                if (u < ulo) ulo = u;
                if (u > uhi) uhi = u;
                if (v < vlo) vlo = v;
                if (v > vhi) vhi = v;
                if (d < dlo) dlo = d;
                if (d > dhi) dhi = d;
            end
            used++;
        end
        ok = used > 0 && !(uhi < 0 || vhi < 0 || ulo > ONE_Q16 || vlo > ONE_Q16);
        r.rect_valid = ok;
        r.u_low      = ok ? 17'(clamp_unit(ulo)) : 17'd0;
        r.v_low      = ok ? 17'(clamp_unit(vlo)) : 17'd0;
        r.u_high     = ok ? 17'(clamp_unit(uhi)) : 17'd0;
        r.v_high     = ok ? 17'(clamp_unit(vhi)) : 17'd0;
        r.depth_low  = ok ? 17'(dlo) : 17'd0;
        r.depth_high = ok ? 17'(dhi) : 17'd0;
        r.tag        = tag;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Drive one beat; sender runs in bursts with random gaps between them.
    task automatic send_item(logic [1:0] op, logic [3:0] slot, logic signed [31:0] val,
                             box_t b, logic [15:0] tag);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_valid = 1'b0;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
        burst_left--;
        s_opcode        = op;
        s_element_slot  = slot;
        s_element_value = val;
        s_box_min_x     = b[0];
        s_box_min_y     = b[1];
        s_box_min_z     = b[2];
        s_box_max_x     = b[3];
        s_box_max_y     = b[4];
        s_box_max_z     = b[5];
        s_object_tag    = tag;
        s_valid         = 1'b1;
        do @(posedge aclk); while (!s_ready);
        // update the shadow state on the accepted beat
        case (op)
            bsrp_pkg::OP_LOAD_PROJ: proj_mat[slot] = val;
            bsrp_pkg::OP_LOAD_VIEW: view_mat[slot] = val;
            bsrp_pkg::OP_PROJECT:   rect_queue.push_back(project_box(b, tag));
            default: ;
        endcase
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    task automatic load_item(logic [1:0] op, logic [3:0] slot, logic signed [31:0] val);
        box_t junk;
        foreach (junk[k]) junk[k] = $urandom;
        send_item(op, slot, val, junk, 16'($urandom));
    endtask

    task automatic project_item(box_t b, logic [15:0] tag);
        send_item(bsrp_pkg::OP_PROJECT, 4'($urandom), $urandom, b, tag);
    endtask

    // Drain results, then hold off for the block's latency before a cfg write.
    task automatic write_planes(logic signed [31:0] near_v, logic signed [31:0] far_v);
        wait (rect_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = bsrp_pkg::REG_NEAR;
        cfg_wdata = near_v;
        @(negedge aclk);
        cfg_index = bsrp_pkg::REG_FAR;
        cfg_wdata = far_v;
        @(negedge aclk);
        cfg_we    = 1'b0;
        near_q    = near_v;
        far_q     = far_v;
    endtask

    // Simple perspective camera: w = -z, view depth = -z.
    task automatic load_camera();
        for (int i = 0; i < 16; i++) begin
            load_item(bsrp_pkg::OP_LOAD_PROJ, 4'(i), (i == 0 || i == 5 || i == 10) ? ONE_Q16 :
                                           (i == 11) ? -ONE_Q16 : 0);
            load_item(bsrp_pkg::OP_LOAD_VIEW, 4'(i), (i == 0 || i == 5 || i == 15) ? ONE_Q16 :
                                           (i == 10) ? -ONE_Q16 : 0);
        end
    endtask

    function automatic box_t make_box(int cx, int cy, int cz, int ex, int ey, int ez);
        box_t b;
        b[0] = cx - ex; b[1] = cy - ey; b[2] = cz - ez;
        b[3] = cx + ex; b[4] = cy + ey; b[5] = cz + ez;
        return b;
    endfunction

    // Box in front of the camera, sometimes straddling the camera plane or off-screen.
    function automatic box_t random_scene_box();
        int cx, cy, cz;
        cx = $urandom_range(0, 80 * ONE_Q16) - 40 * ONE_Q16;
        cy = $urandom_range(0, 80 * ONE_Q16) - 40 * ONE_Q16;
        cz = -$urandom_range(0, 150 * ONE_Q16);
        return make_box(cx, cy, cz, $urandom_range(0, 10 * ONE_Q16),
                        $urandom_range(0, 10 * ONE_Q16), $urandom_range(0, 10 * ONE_Q16));
    endfunction

    task automatic test_directed();
        box_t b;
        // zero matrices after reset: every w is zero, so nothing counts
        project_item(make_box(0, 0, -5 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h0000);
        write_planes(ONE_Q16, 100 * ONE_Q16);
        load_camera();
        project_item(make_box(0, 0, -10 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'hFFFF);
        // box wholly behind the camera
        project_item(make_box(0, 0, 10 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h1234);
        // off-screen on each side
        project_item(make_box(50 * ONE_Q16, 0, -5 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h1);
        project_item(make_box(-50 * ONE_Q16, 0, -5 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h2);
        project_item(make_box(0, 50 * ONE_Q16, -5 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h3);
        project_item(make_box(0, -50 * ONE_Q16, -5 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h4);
        // straddles the camera plane; beyond far plane
        project_item(make_box(0, 0, 0, 3 * ONE_Q16, ONE_Q16, 4 * ONE_Q16), 16'h5);
        project_item(make_box(0, 0, -300 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h6);
        // field extremes
        b[0] = 32'sh8000_0000; b[1] = 32'sh8000_0000; b[2] = 32'sh8000_0000;
        b[3] = 32'sh7FFF_FFFF; b[4] = 32'sh7FFF_FFFF; b[5] = 32'sh7FFF_FFFF;
        project_item(b, 16'hA5A5);
        load_item(bsrp_pkg::OP_LOAD_PROJ, 4'd15, 32'sh7FFF_FFFF);
        project_item(b, 16'h5A5A);
        load_item(bsrp_pkg::OP_LOAD_VIEW, 4'd14, 32'sh8000_0000);
        project_item(make_box(0, 0, -10 * ONE_Q16, 0, 0, 0), 16'h7);
        // opcode 3 does nothing
        load_item(2'd3, 4'd15, 32'sh7FFF_FFFF);
        // far not beyond near
        write_planes(50 * ONE_Q16, 50 * ONE_Q16);
        load_camera();
        project_item(make_box(0, 0, -20 * ONE_Q16, ONE_Q16, ONE_Q16, ONE_Q16), 16'h8);
    endtask

    task automatic test_random(logic signed [31:0] near_v, logic signed [31:0] far_v, int count);
        int pick;
        box_t b;
        write_planes(near_v, far_v);
        load_camera();
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                project_item(random_scene_box(), 16'($urandom));
            end else if (pick < 82) begin
                // set one element to a small value
                load_item(2'($urandom_range(0, 1)), 4'($urandom),
                          $urandom_range(0, 4 * ONE_Q16) - 2 * ONE_Q16);
            end else if (pick < 86) begin
                load_item(2'($urandom_range(0, 1)), 4'($urandom), $urandom);
            end else if (pick < 88) begin
                load_item(2'd3, 4'($urandom), $urandom);
            end else if (pick < 95) begin
                foreach (b[k]) b[k] = $urandom;
                project_item(b, 16'($urandom));
            end else begin
                load_camera();
            end
        end
    endtask

    // Receiver: stretches of always-ready alternate with random stalls.
    initial begin
        int left;
        m_ready = 1'b0;
        left = 0;
        forever begin
            @(negedge aclk);
            if (left == 0) begin
                rx_random = $urandom_range(0, 2) != 0;
                left = $urandom_range(20, 400);
            end
            left--;
            m_ready = rx_random ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // Check each result beat against the oldest prediction.
    initial begin
        rect_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (rect_queue.size() == 0) begin
                    $display("unexpected result beat at %0t", $realtime);
                    error_count++;
                end else begin
                    want = rect_queue.pop_front();
                    if (m_rect_valid !== want.rect_valid)
                        report_mismatch("rect_valid", m_rect_valid, want.rect_valid);
                    if (m_u_low !== want.u_low) report_mismatch("u_low", m_u_low, want.u_low);
                    if (m_v_low !== want.v_low) report_mismatch("v_low", m_v_low, want.v_low);
                    if (m_u_high !== want.u_high)
                        report_mismatch("u_high", m_u_high, want.u_high);
                    if (m_v_high !== want.v_high)
                        report_mismatch("v_high", m_v_high, want.v_high);
                    if (m_depth_low !== want.depth_low)
                        report_mismatch("depth_low", m_depth_low, want.depth_low);
                    if (m_depth_high !== want.depth_high)
                        report_mismatch("depth_high", m_depth_high, want.depth_high);
                    if (m_result_tag !== want.tag)
                        report_mismatch("result_tag", m_result_tag, want.tag);
                end
            end
        end
    end

    // Hard stop well past the slowest passing run.
    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end

    initial begin
        error_count = 0;
        burst_left  = 0;
        rx_random   = 1'b0;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = bsrp_pkg::REG_NEAR;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_opcode    = bsrp_pkg::OP_LOAD_PROJ;
        s_element_slot  = '0;
        s_element_value = '0;
        s_box_min_x = '0; s_box_min_y = '0; s_box_min_z = '0;
        s_box_max_x = '0; s_box_max_y = '0; s_box_max_z = '0;
        s_object_tag = '0;
        foreach (proj_mat[i]) begin
            proj_mat[i] = '0;
            view_mat[i] = '0;
        end
        near_q = '0;
        far_q  = bsrp_pkg::FAR_RESET;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(ONE_Q16, 100 * ONE_Q16, 80);
        test_random(32'sh8000_0000, 32'sh7FFF_FFFF, 60);
        test_random(60 * ONE_Q16, 20 * ONE_Q16, 40);
        test_random(0, bsrp_pkg::FAR_RESET, 70);

        wait (rect_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0 && rect_queue.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
